// ===== hdl/soa_pkg.sv =====
// ----------------------------------------------------------------------------
// soa_pkg: shared types and constants of the slab object allocator
// Geometry, handle layout, status codes and the controller/datapath structs.
// ----------------------------------------------------------------------------
package soa_pkg;

    // Chunk geometry
    localparam int CHUNK_BYTES        = 4096;
    localparam int CHUNK_TAIL_BYTES   = 64;
    localparam int HEAD_BYTES         = 16;
    localparam int NUM_CHUNKS         = 64;
    localparam int NUM_CLASSES        = 4;
    localparam int MAX_OBJS_PER_CHUNK = 128;
    localparam int HEADS_PER_CHUNK    = (CHUNK_BYTES - CHUNK_TAIL_BYTES) / HEAD_BYTES;

    // Field widths
    localparam int HANDLE_W   = 13;
    localparam int LINK_W     = HANDLE_W + 1;
    localparam int OBJ_BITS   = $clog2(MAX_OBJS_PER_CHUNK);
    localparam int CHUNK_BITS = HANDLE_W - OBJ_BITS;
    localparam int CNT_W      = OBJ_BITS + 1;
    localparam int CLS_W      = $clog2(NUM_CLASSES);
    localparam int CSIZE_W    = 12;
    localparam int SIZE_W     = 16;
    localparam int BYTES_W    = 32;
    localparam int DIV_W      = 16;
    localparam int CHUNK_ENT_W = CLS_W + CNT_W;

    // Null link: top bit set
    localparam logic [LINK_W-1:0] LINK_NIL = {LINK_W{1'b1}};

    // Result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BYPASS = 2'd1;
    localparam logic [1:0] ST_NOMEM  = 2'd2;
    localparam logic [1:0] ST_BADH   = 2'd3;

    // Request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [NUM_CLASSES-1:0][CSIZE_W-1:0] t_csize_arr;

    // Controller to datapath
    typedef struct packed {
        logic       load;
        logic       div_start;
        logic       n_load;
        logic       st_we;
        logic [1:0] st_val;
        logic       scan_clr;
        logic       scan_inc;
        logic       claim;
        logic       fill_step;
        logic       pop_rd;
        logic       pop_wr;
        logic       free_rd;
        logic       free_push1;
        logic       free_push2;
        logic       rel_clr;
        logic       rel_rd;
        logic       rel_wr;
        logic       fin;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic found;
        logic is_free;
        logic div_done;
        logic head_null;
        logic n_zero;
        logic free_pre_bad;
        logic scan_busy;
        logic scan_last;
        logic k_last;
        logic free_bad;
        logic cnt_zero;
        logic out_busy;
    } t_dp_stat;

endpackage

// ===== hdl/soa_ram.sv =====
// ----------------------------------------------------------------------------
// soa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module soa_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/soa_div.sv =====
// ----------------------------------------------------------------------------
// soa_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, done pulse at the end.
// ----------------------------------------------------------------------------
module soa_div #(
    parameter int W = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quot
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_div;
    logic [W:0]    shifted;
    logic [W:0]    trial;

    // trial subtract of the shifted remainder
    always_comb begin
        shifted = {r_rem, r_quo[W-1]};
        trial   = shifted - {1'b0, r_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!trial[W]) begin
                r_rem <= trial[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== hdl/soa_ctrl.sv =====
// ----------------------------------------------------------------------------
// soa_ctrl: request sequencer
// Steps each request through class match, geometry, list and chunk updates.
// ----------------------------------------------------------------------------
module soa_ctrl import soa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLASS    = 4'd1;
    localparam logic [3:0] S_DIV      = 4'd4;
    localparam logic [3:0] S_BRANCH   = 4'd5;
    localparam logic [3:0] S_SCAN     = 4'd6;
    localparam logic [3:0] S_FILL     = 4'd7;
    localparam logic [3:0] S_POP_RD   = 4'd8;
    localparam logic [3:0] S_POP_WR   = 4'd9;
    localparam logic [3:0] S_FREE_CHK = 4'd10;
    localparam logic [3:0] S_PUSH2    = 4'd11;
    localparam logic [3:0] S_REL_RD   = 4'd12;
    localparam logic [3:0] S_REL_WR   = 4'd13;
    localparam logic [3:0] S_FIN      = 4'd14;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CLASS;
                end
            end
            S_CLASS: begin
                if (!i_stat.found) begin
                    o_cmd.st_we  = 1'b1;
                    o_cmd.st_val = ST_BYPASS;
                    n_state      = S_FIN;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.n_load = 1'b1;
                    n_state      = S_BRANCH;
                end
            end
            S_BRANCH: begin
                if (!i_stat.is_free) begin
                    if (!i_stat.head_null) begin
                        n_state = S_POP_RD;
                    end else if (i_stat.n_zero) begin
                        o_cmd.st_we  = 1'b1;
                        o_cmd.st_val = ST_NOMEM;
                        n_state      = S_FIN;
                    end else begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end
                end else if (i_stat.free_pre_bad) begin
                    o_cmd.st_we  = 1'b1;
                    o_cmd.st_val = ST_BADH;
                    n_state      = S_FIN;
                end else begin
                    o_cmd.free_rd = 1'b1;
                    n_state       = S_FREE_CHK;
                end
            end
            S_SCAN: begin
                if (!i_stat.scan_busy) begin
                    o_cmd.claim = 1'b1;
                    n_state     = S_FILL;
                end else if (i_stat.scan_last) begin
                    o_cmd.st_we  = 1'b1;
                    o_cmd.st_val = ST_NOMEM;
                    n_state      = S_FIN;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.k_last) begin
                    n_state = S_POP_RD;
                end
            end
            S_POP_RD: begin
                o_cmd.pop_rd = 1'b1;
                n_state      = S_POP_WR;
            end
            S_POP_WR: begin
                o_cmd.pop_wr = 1'b1;
                o_cmd.st_we  = 1'b1;
                o_cmd.st_val = ST_OK;
                n_state      = S_FIN;
            end
            S_FREE_CHK: begin
                if (i_stat.free_bad) begin
                    o_cmd.st_we  = 1'b1;
                    o_cmd.st_val = ST_BADH;
                    n_state      = S_FIN;
                end else begin
                    o_cmd.free_push1 = 1'b1;
                    n_state          = S_PUSH2;
                end
            end
            S_PUSH2: begin
                o_cmd.free_push2 = 1'b1;
                if (i_stat.cnt_zero) begin
                    o_cmd.rel_clr = 1'b1;
                    n_state       = S_REL_RD;
                end else begin
                    o_cmd.st_we  = 1'b1;
                    o_cmd.st_val = ST_OK;
                    n_state      = S_FIN;
                end
            end
            S_REL_RD: begin
                o_cmd.rel_rd = 1'b1;
                n_state      = S_REL_WR;
            end
            S_REL_WR: begin
                o_cmd.rel_wr = 1'b1;
                if (i_stat.k_last) begin
                    o_cmd.st_we  = 1'b1;
                    o_cmd.st_val = ST_OK;
                    n_state      = S_FIN;
                end else begin
                    n_state = S_REL_RD;
                end
            end
            S_FIN: begin
                if (!i_stat.out_busy) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== hdl/soa_datapath.sv =====
// ----------------------------------------------------------------------------
// soa_datapath: allocator state and list manipulation
// Class match, geometry divider, chunk table, link memories, byte total.
// ----------------------------------------------------------------------------
module soa_datapath import soa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  t_csize_arr          i_class_size,
    input  logic                i_opcode,
    input  logic [SIZE_W-1:0]   i_size_bytes,
    input  logic [HANDLE_W-1:0] i_obj_handle,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [1:0]          o_status,
    output logic [HANDLE_W-1:0] o_result_handle,
    output logic [BYTES_W-1:0]  o_bytes_in_use
);

    localparam int HEAD_SH = $clog2(HEAD_BYTES);

    // request registers
    logic                  r_op;
    logic [SIZE_W-1:0]     r_size;
    logic [HANDLE_W-1:0]   r_h;
    logic                  r_found;
    logic [CLS_W-1:0]      r_q;
    logic [CNT_W-1:0]      r_n;
    logic [1:0]            r_status;
    logic [CHUNK_BITS-1:0] r_scan;
    logic [CHUNK_BITS-1:0] r_chunk;
    logic [CNT_W-1:0]      r_k;
    logic [HANDLE_W-1:0]   r_obj;
    logic                  r_cnt_zero;

    // allocator state
    logic [NUM_CHUNKS-1:0] r_active;
    logic [LINK_W-1:0]     r_head [NUM_CLASSES];
    logic [LINK_W-1:0]     r_tail [NUM_CLASSES];
    logic [BYTES_W-1:0]    r_total;

    // result register
    logic                  r_out_valid;
    logic [1:0]            r_out_status;
    logic [HANDLE_W-1:0]   r_out_handle;
    logic [BYTES_W-1:0]    r_out_total;

    // class match
    logic                  f_found;
    logic [CLS_W-1:0]      f_q;
    logic                  f_stop;

    always_comb begin
        f_found = 1'b0;
        f_q     = '0;
        f_stop  = 1'b0;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if (!f_stop) begin
                if (i_class_size[i] == '0 ||
                    {{(SIZE_W-CSIZE_W){1'b0}}, i_class_size[i]} > i_size_bytes) begin
                    f_stop = 1'b1;
                end else if ({{(SIZE_W-CSIZE_W){1'b0}}, i_class_size[i]} == i_size_bytes) begin
                    f_found = 1'b1;
                    f_q     = CLS_W'(i);
                    f_stop  = 1'b1;
                end
            end
        end
    end

    // geometry: stride = ceil(size/HEAD)+1 by shift, then objects = HEADS/stride
    logic [CSIZE_W-1:0] csize_q;
    logic [DIV_W-1:0]   div_a;
    logic [DIV_W-1:0]   div_b;
    logic               div_done;
    logic [DIV_W-1:0]   quot;
    logic [CNT_W-1:0]   n_cap;

    assign csize_q = i_class_size[r_q];
    assign div_a   = DIV_W'(HEADS_PER_CHUNK);
    assign div_b   = ((DIV_W'(csize_q) + DIV_W'(HEAD_BYTES - 1)) >> HEAD_SH) + DIV_W'(1);
    assign n_cap   = (quot > DIV_W'(MAX_OBJS_PER_CHUNK)) ? CNT_W'(MAX_OBJS_PER_CHUNK)
                                                         : quot[CNT_W-1:0];

    soa_div #(.W(DIV_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // memories
    logic                   nx_we, pv_we, on_we, ch_we;
    logic [HANDLE_W-1:0]    nx_wa, pv_wa, on_wa, nx_ra, pv_ra, on_ra;
    logic [LINK_W-1:0]      nx_wd, pv_wd, nx_rd, pv_rd;
    logic                   on_wd, on_rd;
    logic [CHUNK_BITS-1:0]  ch_wa, ch_ra;
    logic [CHUNK_ENT_W-1:0] ch_wd, ch_rd;

    soa_ram #(.W(LINK_W), .D(NUM_CHUNKS * MAX_OBJS_PER_CHUNK)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_wa), .i_wdata(nx_wd),
        .i_raddr(nx_ra), .o_rdata(nx_rd)
    );

    soa_ram #(.W(LINK_W), .D(NUM_CHUNKS * MAX_OBJS_PER_CHUNK)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_wa), .i_wdata(pv_wd),
        .i_raddr(pv_ra), .o_rdata(pv_rd)
    );

    soa_ram #(.W(1), .D(NUM_CHUNKS * MAX_OBJS_PER_CHUNK)) u_onlist (
        .i_clk(i_clk), .i_we(on_we), .i_waddr(on_wa), .i_wdata(on_wd),
        .i_raddr(on_ra), .o_rdata(on_rd)
    );

    soa_ram #(.W(CHUNK_ENT_W), .D(NUM_CHUNKS)) u_chunk (
        .i_clk(i_clk), .i_we(ch_we), .i_waddr(ch_wa), .i_wdata(ch_wd),
        .i_raddr(ch_ra), .o_rdata(ch_rd)
    );

    // derived values
    logic [LINK_W-1:0]     head_q, tail_q;
    logic [CNT_W-1:0]      k_nxt, k_prv, n_m1;
    logic [HANDLE_W-1:0]   obj_i;
    logic                  k_last;
    logic [CHUNK_BITS-1:0] fc;
    logic [OBJ_BITS-1:0]   fk;
    logic [CLS_W-1:0]      cls_rd;
    logic [CNT_W-1:0]      cnt_rd, cnt_inc, cnt_dec;
    logic                  free_bad;

    assign head_q  = r_head[r_q];
    assign tail_q  = r_tail[r_q];
    assign k_nxt   = r_k + 1'b1;
    assign k_prv   = r_k - 1'b1;
    assign n_m1    = r_n - 1'b1;
    assign obj_i   = {r_chunk, r_k[OBJ_BITS-1:0]};
    assign k_last  = (r_k == n_m1);
    assign fc      = r_h[HANDLE_W-1:OBJ_BITS];
    assign fk      = r_h[OBJ_BITS-1:0];
    assign cls_rd  = ch_rd[CHUNK_ENT_W-1:CNT_W];
    assign cnt_rd  = ch_rd[CNT_W-1:0];
    assign cnt_inc = cnt_rd + 1'b1;
    assign cnt_dec = cnt_rd - 1'b1;
    assign free_bad = (cls_rd != r_q) | ({1'b0, fk} >= r_n) | on_rd | (cnt_rd == '0);

    // memory port selection
    always_comb begin
        nx_we = 1'b0; nx_wa = obj_i; nx_wd = LINK_NIL; nx_ra = obj_i;
        pv_we = 1'b0; pv_wa = obj_i; pv_wd = LINK_NIL; pv_ra = obj_i;
        on_we = 1'b0; on_wa = obj_i; on_wd = 1'b0;     on_ra = obj_i;
        ch_we = 1'b0; ch_wa = r_chunk; ch_wd = {cls_rd, cnt_inc}; ch_ra = fc;
        // new chunk: owner class, zero uses
        if (i_cmd.claim) begin
            ch_we = 1'b1;
            ch_wa = r_scan;
            ch_wd = {r_q, CNT_W'(0)};
        end
        // chain the chunk's objects in slot order
        if (i_cmd.fill_step) begin
            nx_we = 1'b1;
            nx_wd = k_last ? LINK_NIL : {1'b0, r_chunk, k_nxt[OBJ_BITS-1:0]};
            pv_we = 1'b1;
            pv_wd = (r_k == '0) ? LINK_NIL : {1'b0, r_chunk, k_prv[OBJ_BITS-1:0]};
            on_we = 1'b1;
            on_wd = 1'b1;
        end
        // pop the head
        if (i_cmd.pop_rd) begin
            nx_ra = head_q[HANDLE_W-1:0];
            ch_ra = head_q[HANDLE_W-1:OBJ_BITS];
        end
        if (i_cmd.pop_wr) begin
            if (!nx_rd[LINK_W-1]) begin
                pv_we = 1'b1;
                pv_wa = nx_rd[HANDLE_W-1:0];
                pv_wd = LINK_NIL;
            end
            on_we = 1'b1;
            on_wa = r_obj;
            on_wd = 1'b0;
            ch_we = 1'b1;
            ch_wa = r_obj[HANDLE_W-1:OBJ_BITS];
            ch_wd = {cls_rd, cnt_inc};
        end
        // free: look up chunk and listed bit
        if (i_cmd.free_rd) begin
            ch_ra = fc;
            on_ra = r_h;
        end
        // free: append at tail, first half
        if (i_cmd.free_push1) begin
            ch_we = 1'b1;
            ch_wa = fc;
            ch_wd = {cls_rd, cnt_dec};
            nx_we = 1'b1;
            nx_wa = r_h;
            nx_wd = LINK_NIL;
            pv_we = 1'b1;
            pv_wa = r_h;
            pv_wd = tail_q;
            on_we = 1'b1;
            on_wa = r_h;
            on_wd = 1'b1;
        end
        // free: link old tail to the object
        if (i_cmd.free_push2 && !tail_q[LINK_W-1]) begin
            nx_we = 1'b1;
            nx_wa = tail_q[HANDLE_W-1:0];
            nx_wd = {1'b0, r_h};
        end
        // release sweep: unlink each listed object
        if (i_cmd.rel_rd) begin
            nx_ra = obj_i;
            pv_ra = obj_i;
            on_ra = obj_i;
        end
        if (i_cmd.rel_wr && on_rd) begin
            if (!pv_rd[LINK_W-1]) begin
                nx_we = 1'b1;
                nx_wa = pv_rd[HANDLE_W-1:0];
                nx_wd = nx_rd;
            end
            if (!nx_rd[LINK_W-1]) begin
                pv_we = 1'b1;
                pv_wa = nx_rd[HANDLE_W-1:0];
                pv_wd = pv_rd;
            end
            on_we = 1'b1;
            on_wa = obj_i;
            on_wd = 1'b0;
        end
    end

    // byte total with saturation
    logic [BYTES_W:0]     sum;
    logic [BYTES_W-1:0]   size_ext;
    logic [BYTES_W-1:0]   add_sat;
    logic [BYTES_W-1:0]   sub_sat;
    logic [BYTES_W-1:0]   n_total;
    logic                 total_chg;

    assign size_ext  = {{(BYTES_W-SIZE_W){1'b0}}, r_size};
    assign sum       = {1'b0, r_total} + {1'b0, size_ext};
    assign add_sat   = sum[BYTES_W] ? {BYTES_W{1'b1}} : sum[BYTES_W-1:0];
    assign sub_sat   = (r_total < size_ext) ? '0 : r_total - size_ext;
    assign total_chg = (r_status == ST_OK) || (r_status == ST_BYPASS);
    assign n_total   = !total_chg ? r_total : ((r_op == OP_ALLOC) ? add_sat : sub_sat);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_head[i] <= LINK_NIL;
                r_tail[i] <= LINK_NIL;
            end
        end else begin
            if (i_cmd.claim) begin
                r_active[r_scan] <= 1'b1;
            end
            if (i_cmd.rel_wr && k_last) begin
                r_active[r_chunk] <= 1'b0;
            end
            if (i_cmd.fill_step && k_last) begin
                r_head[r_q] <= {1'b0, r_chunk, {OBJ_BITS{1'b0}}};
                r_tail[r_q] <= {1'b0, obj_i};
            end
            if (i_cmd.pop_wr) begin
                r_head[r_q] <= nx_rd;
                if (nx_rd[LINK_W-1]) begin
                    r_tail[r_q] <= LINK_NIL;
                end
            end
            if (i_cmd.free_push2) begin
                if (tail_q[LINK_W-1]) begin
                    r_head[r_q] <= {1'b0, r_h};
                end
                r_tail[r_q] <= {1'b0, r_h};
            end
            if (i_cmd.rel_wr && on_rd) begin
                if (pv_rd[LINK_W-1]) begin
                    r_head[r_q] <= nx_rd;
                end
                if (nx_rd[LINK_W-1]) begin
                    r_tail[r_q] <= pv_rd;
                end
            end
            if (i_cmd.fin) begin
                r_total <= n_total;
            end
            r_out_valid <= i_cmd.fin | (r_out_valid & ~i_out_ready);
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_size  <= i_size_bytes;
            r_h     <= i_obj_handle;
            r_found <= f_found;
            r_q     <= f_q;
        end
        if (i_cmd.n_load) begin
            r_n <= n_cap;
        end
        if (i_cmd.st_we) begin
            r_status <= i_cmd.st_val;
        end
        if (i_cmd.scan_clr) begin
            r_scan <= '0;
        end else if (i_cmd.scan_inc) begin
            r_scan <= r_scan + 1'b1;
        end
        if (i_cmd.claim) begin
            r_chunk <= r_scan;
        end else if (i_cmd.free_rd) begin
            r_chunk <= fc;
        end
        if (i_cmd.claim || i_cmd.rel_clr) begin
            r_k <= '0;
        end else if (i_cmd.fill_step || i_cmd.rel_wr) begin
            r_k <= k_nxt;
        end
        if (i_cmd.pop_rd) begin
            r_obj <= head_q[HANDLE_W-1:0];
        end
        if (i_cmd.free_push1) begin
            r_cnt_zero <= (cnt_dec == '0);
        end
        if (i_cmd.fin) begin
            r_out_status <= r_status;
            r_out_handle <= ((r_status == ST_OK) && (r_op == OP_ALLOC)) ? r_obj : '0;
            r_out_total  <= n_total;
        end
    end

    // status to the controller
    always_comb begin
        o_stat.found        = r_found;
        o_stat.is_free      = (r_op == OP_FREE);
        o_stat.div_done     = div_done;
        o_stat.head_null    = head_q[LINK_W-1];
        o_stat.n_zero       = (r_n == '0);
        o_stat.free_pre_bad = ~r_active[fc];
        o_stat.scan_busy    = r_active[r_scan];
        o_stat.scan_last    = (r_scan == CHUNK_BITS'(NUM_CHUNKS - 1));
        o_stat.k_last       = k_last;
        o_stat.free_bad     = free_bad;
        o_stat.cnt_zero     = r_cnt_zero;
        o_stat.out_busy     = r_out_valid & ~i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_result_handle = r_out_handle;
    assign o_bytes_in_use  = r_out_total;

`ifndef SYNTH
    // a chunk is claimed before it is chained
    a_fill_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill_step |-> r_active[r_chunk])
        else $error("fill on an inactive chunk");

    // the last release step frees the chunk
    a_rel_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.rel_wr && k_last) |=> !r_active[$past(r_chunk)])
        else $error("chunk still active after release");

    // head and tail of a list are empty together, once a class is selected
    a_list_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(r_q) |-> (head_q[LINK_W-1] == tail_q[LINK_W-1]))
        else $error("list head and tail disagree");

    // only a successful alloc returns a handle
    a_handle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ST_OK) |-> (r_out_handle == '0))
        else $error("handle on a failed request");
`endif

endmodule

// ===== hdl/slab_object_allocator_top.sv =====
// ----------------------------------------------------------------------------
// slab_object_allocator_top: slab object allocator
// Class-size registers on an APB-style port, sequencer and datapath.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives one result. A request whose size
// matches no class skips the rest and finishes after the class match. Every
// class request first runs a division for the objects per chunk. An alloc on
// an empty list adds a chunk scan, one chunk after another (up to 64), and
// chains the new chunk's objects one by one (up to 126). A free that empties
// its chunk adds a release sweep over its objects, each read from and then
// written back to the link memories. A new request is taken while the
// previous result waits in the output register.
// ----------------------------------------------------------------------------
module slab_object_allocator_top import soa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // requests
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_opcode,
    input  logic [SIZE_W-1:0]   i_size_bytes,
    input  logic [HANDLE_W-1:0] i_obj_handle,
    // results
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_status,
    output logic [HANDLE_W-1:0] o_result_handle,
    output logic [BYTES_W-1:0]  o_bytes_in_use
);

    t_csize_arr r_class_size;
    t_dp_cmd    cmd;
    t_dp_stat   stat;
    logic       cfg_wr;

    // class size registers
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_size <= '0;
        end else if (cfg_wr) begin
            r_class_size[paddr[3:2]] <= pwdata[CSIZE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {{(32-CSIZE_W){1'b0}}, r_class_size[paddr[3:2]]};

    soa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    soa_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_class_size    (r_class_size),
        .i_opcode        (i_opcode),
        .i_size_bytes    (i_size_bytes),
        .i_obj_handle    (i_obj_handle),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_result_handle (o_result_handle),
        .o_bytes_in_use  (o_bytes_in_use)
    );

endmodule
